[rtl/ins_sort_pkg.sv]
`default_nettype none
package ins_sort_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic  ins;    // insert ins_val into the list
    logic  shift;  // shift the list down by one place
    data_t ins_val;
  } cell_ctl_t;

endpackage
`default_nettype wire

[rtl/ins_sort_cell.sv]
`default_nettype none
module ins_sort_cell (
  input  wire                    clk,
  input  ins_sort_pkg::cell_ctl_t ctl,
  input  wire                    occ,
  input  wire                    prev_occ,
  input  wire                    prev_gt,
  input  ins_sort_pkg::data_t    prev_data,
  input  ins_sort_pkg::data_t    next_data,
  output logic                   gt,
  output ins_sort_pkg::data_t    data
);
  import ins_sort_pkg::*;

  logic take_new;

  // Occupied and strictly greater than the new value: this one moves up.
  assign gt       = occ && (data > ctl.ins_val);
  assign take_new = prev_occ && !prev_gt && (gt || !occ);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (prev_gt) begin
        data <= prev_data;
      end else if (take_new) begin
        data <= ctl.ins_val;
      end
    end else if (ctl.shift) begin
      data <= next_data;
    end
  end

endmodule
`default_nettype wire

[rtl/ins_sort_ctrl.sv]
`default_nettype none
module ins_sort_ctrl (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  input  wire                          in_last,
  input  ins_sort_pkg::data_t          in_value,
  input  wire                          out_stall,
  output logic                         in_stall,
  output logic                         out_valid,
  output logic                         final_res,
  output logic                         overflow,
  output logic [ins_sort_pkg::CNT_W-1:0] count,
  output ins_sort_pkg::cell_ctl_t      ctl
);
  import ins_sort_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] count_next;
  logic             dropped, dropped_next;
  logic             in_acc, full, out_acc, drain_end;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign full      = (count == FULL_CNT);
  assign drain_end = out_acc && (count == ONE_CNT);

  assign ctl.ins     = in_acc && !full;
  assign ctl.shift   = out_acc;
  assign ctl.ins_val = in_value;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: if (in_acc && in_last) state_next = ST_DRAIN;
      ST_DRAIN:   if (drain_end) state_next = ST_COLLECT;
      default:    state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_stall  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_COLLECT: begin
        in_stall  = 1'b0;
        out_valid = 1'b0;
      end
      ST_DRAIN: begin
        in_stall  = 1'b1;
        out_valid = 1'b1;
      end
      default: begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_next   = count;
    dropped_next = dropped;
    if (ctl.ins) begin
      count_next = count + ONE_CNT;
    end else if (out_acc) begin
      count_next = count - ONE_CNT;
    end
    if (in_acc && full) begin
      dropped_next = 1'b1;
    end else if (drain_end) begin
      dropped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_COLLECT;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
    end
  end

  assign final_res = (count == ONE_CNT);
  assign overflow  = dropped;

endmodule
`default_nettype wire

[rtl/insertion_sorter.sv]
`default_nettype none
// Streaming insertion sorter for signed 32-bit values. Values arrive one per
// item on the input channel and drop into a chain of 64 compare-and-shift
// cells that keeps the set in ascending order at all times; equal values keep
// their arrival order. Collection runs at one item per cycle. The item marked
// last is inserted like the others and then starts the drain: the list comes
// out smallest first, one result per cycle while out_stall is low, with
// final_res on the last one. During the drain in_stall stays high, so no
// value of the next set is taken until the drain is over. Values that
// arrive while all 64 cells are full are dropped, and every result of that
// set then carries overflow. A dropped value marked last still ends the
// set. Once the final result is taken the store is empty and the next set
// may begin.
module insertion_sorter (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  ins_sort_pkg::data_t value,
  input  wire                 last,
  output logic                out_valid,
  input  wire                 out_stall,
  output ins_sort_pkg::data_t sorted_value,
  output logic                final_res,
  output logic                overflow
);
  import ins_sort_pkg::*;

  cell_ctl_t        ctl;
  logic [CNT_W-1:0] count;
  data_t            cell_data [MAX_ITEMS];
  logic             cell_gt   [MAX_ITEMS];
  logic             cell_occ  [MAX_ITEMS];

  // Control: fill count, overflow flag and collect/drain sequencing.
  ins_sort_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (last),
    .in_value  (value),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .final_res (final_res),
    .overflow  (overflow),
    .count     (count),
    .ctl       (ctl)
  );

  // Cell chain. Cell 0 holds the smallest value; the occupied cells are
  // always the lowest `count` ones, so occupancy follows from the count.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic  prev_occ;
    logic  prev_gt;
    data_t prev_data;
    data_t next_data;

    assign cell_occ[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      // Nothing below the head: treat it as an occupied, smaller neighbor.
      assign prev_occ  = 1'b1;
      assign prev_gt   = 1'b0;
      assign prev_data = cell_data[i];
    end else begin : g_body
      assign prev_occ  = cell_occ[i-1];
      assign prev_gt   = cell_gt[i-1];
      assign prev_data = cell_data[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      // Top cell goes empty on a shift; its content no longer matters.
      assign next_data = cell_data[i];
    end else begin : g_inner
      assign next_data = cell_data[i+1];
    end

    ins_sort_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (cell_occ[i]),
      .prev_occ  (prev_occ),
      .prev_gt   (prev_gt),
      .prev_data (prev_data),
      .next_data (next_data),
      .gt        (cell_gt[i]),
      .data      (cell_data[i])
    );
  end

  // Head of the chain is the next result; a taken result shifts the chain.
  assign sorted_value = cell_data[0];

endmodule
`default_nettype wire

[rtl/ins_sort_chk.sv]
`default_nettype none
module ins_sort_chk (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_valid,
  input wire                 in_stall,
  input wire                 last,
  input wire                 out_valid,
  input wire                 out_stall,
  input ins_sort_pkg::data_t sorted_value,
  input wire                 final_res
);
  import ins_sort_pkg::*;

  // No item is taken while results are being given out.
  a_no_input_in_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted during drain");

  // A last item starts the drain in the next cycle.
  a_last_starts_drain: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last) |=> out_valid)
    else $error("last item did not start drain");

  // The run continues until the marked final result is taken.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !final_res) |=> out_valid)
    else $error("run ended before final result");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && final_res) |=> !out_valid)
    else $error("result after final result");

  // Ascending order: consecutive results of one run never decrease.
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    ($past(out_valid && !out_stall && !final_res) && out_valid)
      |-> (sorted_value >= $past(sorted_value)))
    else $error("results out of order");

endmodule

bind insertion_sorter ins_sort_chk u_ins_sort_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .last         (last),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .sorted_value (sorted_value),
  .final_res    (final_res)
);
`default_nettype wire
